// ----- hw/rtl/q2a_pkg.sv -----
package q2a_pkg;

  // Field and datapath widths
  localparam int QW       = 16;  // quaternion and output field width
  localparam int GW       = 20;  // rounded Q14 intermediates, unsaturated
  localparam int PW       = 32;  // 16x16 products
  localparam int SW       = 36;  // product sums before rounding
  localparam int SQ_BITS  = 28;  // root bits of the magnitude
  localparam int RAD_W    = 2 * SQ_BITS;
  localparam int CD_IN_W  = 30;  // CORDIC operand width at entry
  localparam int CD_W     = 48;  // CORDIC x/y datapath
  localparam int Z_W      = 35;  // Q30 angle accumulator
  localparam int ANG_W    = 16;  // Q13 angle output
  localparam int ATAN_LEN = 24;

  localparam logic signed [Z_W-1:0]   PI_Q30 = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] PI_Q13 = 16'sd25736;

  // Values carried alongside the magnitude and CORDIC pipelines
  typedef struct packed {
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic signed [GW-1:0] gz;
    logic signed [GW-1:0] yn;
    logic signed [GW-1:0] yd;
  } side_t;

  // Q28 sum to Q14, ties upward
  function automatic logic signed [GW-1:0] rnd_q14(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + 36'sd8192) >>> 14;
    return t[GW-1:0];
  endfunction

  // Saturate a Q14 intermediate to the 16-bit output range
  function automatic logic signed [QW-1:0] sat_q14(input logic signed [GW-1:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[QW-1:0];
  endfunction

  // atan(2^-i) in Q30 radians, floored
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:    return 35'sd843314856;
      5'd1:    return 35'sd497837829;
      5'd2:    return 35'sd263043836;
      5'd3:    return 35'sd133525158;
      5'd4:    return 35'sd67021686;
      5'd5:    return 35'sd33543515;
      5'd6:    return 35'sd16775850;
      5'd7:    return 35'sd8388437;
      5'd8:    return 35'sd4194282;
      5'd9:    return 35'sd2097149;
      5'd10:   return 35'sd1048575;
      5'd11:   return 35'sd524287;
      5'd12:   return 35'sd262143;
      5'd13:   return 35'sd131071;
      5'd14:   return 35'sd65535;
      5'd15:   return 35'sd32767;
      5'd16:   return 35'sd16383;
      5'd17:   return 35'sd8191;
      5'd18:   return 35'sd4095;
      5'd19:   return 35'sd2047;
      5'd20:   return 35'sd1023;
      5'd21:   return 35'sd511;
      5'd22:   return 35'sd255;
      5'd23:   return 35'sd127;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/q2a_quat_if.sv -----
interface q2a_quat_if;
  logic                             valid;
  logic                             ready;
  logic signed [q2a_pkg::QW-1:0] quat_w;
  logic signed [q2a_pkg::QW-1:0] quat_x;
  logic signed [q2a_pkg::QW-1:0] quat_y;
  logic signed [q2a_pkg::QW-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

// ----- hw/rtl/q2a_att_if.sv -----
interface q2a_att_if;
  logic                             valid;
  logic                             ready;
  logic signed [q2a_pkg::QW-1:0]    grav_x;
  logic signed [q2a_pkg::QW-1:0]    grav_y;
  logic signed [q2a_pkg::QW-1:0]    grav_z;
  logic signed [q2a_pkg::ANG_W-1:0] roll_angle;
  logic signed [q2a_pkg::ANG_W-1:0] pitch_angle;
  logic signed [q2a_pkg::ANG_W-1:0] yaw_angle;

  modport source (output valid, output grav_x, output grav_y, output grav_z,
                  output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input grav_x, input grav_y, input grav_z,
                  input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

// ----- hw/rtl/q2a_isqrt.sv -----
// Pipelined floor square root, one root bit per stage
module q2a_isqrt (
  input  logic                              clk_i,
  input  logic [q2a_pkg::SQ_BITS-1:0]       en_i,
  input  logic [q2a_pkg::RAD_W-1:0]         rad_i,
  output logic [q2a_pkg::SQ_BITS-1:0]       root_o
);

  localparam int NB = q2a_pkg::SQ_BITS;
  localparam int RW = q2a_pkg::RAD_W;

  logic [RW-1:0] rem_q  [NB];
  logic [NB-1:0] root_q [NB];

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam int K = NB - 1 - j;
    logic [RW-1:0] rem_in;
    logic [NB-1:0] root_in;
    logic [RW:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (2r + 2^K) * 2^K: what setting root bit K adds to r^2
    assign trial = ((RW+1)'(root_in) << (K + 1)) | ((RW+1)'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[j]  <= rem_in - trial[RW-1:0];
          root_q[j] <= root_in | (NB'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[NB-1];

endmodule

// ----- hw/rtl/q2a_cordic.sv -----
// Vectoring CORDIC atan2: entry stage, STAGES rotations, rounding stage
module q2a_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                clk_i,
  input  logic [STAGES+1:0]                   en_i,
  input  logic signed [q2a_pkg::CD_IN_W-1:0]  y_i,
  input  logic signed [q2a_pkg::CD_IN_W-1:0]  x_i,
  output logic signed [q2a_pkg::ANG_W-1:0]    ang_o
);

  localparam int CW = q2a_pkg::CD_W;
  localparam int ZW = q2a_pkg::Z_W;

  logic signed [CW-1:0] x_q [STAGES+1];
  logic signed [CW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic                 zero_q [STAGES+1];
  logic signed [q2a_pkg::ANG_W-1:0] ang_q;

  // Entry: fold the left half plane, scale by 2^16
  logic signed [CW-1:0] xe, ye;
  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= (-xe) <<< 16;
        y_q[0] <= (-ye) <<< 16;
        z_q[0] <= (y_i >= 0) ? q2a_pkg::PI_Q30 : -q2a_pkg::PI_Q30;
      end else begin
        x_q[0] <= xe <<< 16;
        y_q[0] <= ye <<< 16;
        z_q[0] <= '0;
      end
    end
  end

  // Rotation stages; zero y counts as positive
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = q2a_pkg::atan_q30(5'(i));

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end
      end
    end
  end

  // Q30 to Q13 with rounding, clamp to +-pi; a zero vector gives zero
  logic signed [ZW-1:0] zr;
  assign zr = (z_q[STAGES] + 35'sd65536) >>> 17;

  always_ff @(posedge clk_i) begin
    if (en_i[STAGES+1]) begin
      if (zero_q[STAGES]) begin
        ang_q <= '0;
      end else if (zr > ZW'(q2a_pkg::PI_Q13)) begin
        ang_q <= q2a_pkg::PI_Q13;
      end else if (zr < -ZW'(q2a_pkg::PI_Q13)) begin
        ang_q <= -q2a_pkg::PI_Q13;
      end else begin
        ang_q <= zr[q2a_pkg::ANG_W-1:0];
      end
    end
  end

  assign ang_o = ang_q;

endmodule

// ----- hw/rtl/quaternion_to_attitude_core.sv -----
// Throughput: one request per cycle unless the output stalls; each stage
// advances when it is empty or the stage after it advances, so bubbles close
// up under output backpressure. Depth is set by 4 product/rounding stages,
// the 28-stage magnitude root, CORDIC_STAGES + 2 CORDIC stages and the
// output register.
// Reset clears the valid bits only; datapath registers are not reset.
module quaternion_to_attitude_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  q2a_quat_if.sink     quat_i,
  q2a_att_if.source    att_o
);

  localparam int SQ_FIRST = 4;
  localparam int CD_FIRST = SQ_FIRST + q2a_pkg::SQ_BITS;
  localparam int OUT_IDX  = CD_FIRST + CORDIC_STAGES + 2;
  localparam int N        = OUT_IDX + 1;
  localparam int PW       = q2a_pkg::PW;
  localparam int SW       = q2a_pkg::SW;
  localparam int GW       = q2a_pkg::GW;
  localparam int CIW      = q2a_pkg::CD_IN_W;

  // Stage valids and advance chain
  logic [N-1:0] v_q;
  logic [N-1:0] en;

  assign en[N-1] = ~v_q[N-1] | att_o.ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign quat_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= quat_i.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: quaternion products
  logic signed [PW-1:0] p_xz_q, p_wy_q, p_wx_q, p_yz_q, p_ww_q;
  logic signed [PW-1:0] p_xx_q, p_yy_q, p_zz_q, p_xy_q, p_wz_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_xz_q <= quat_i.quat_x * quat_i.quat_z;
      p_wy_q <= quat_i.quat_w * quat_i.quat_y;
      p_wx_q <= quat_i.quat_w * quat_i.quat_x;
      p_yz_q <= quat_i.quat_y * quat_i.quat_z;
      p_ww_q <= quat_i.quat_w * quat_i.quat_w;
      p_xx_q <= quat_i.quat_x * quat_i.quat_x;
      p_yy_q <= quat_i.quat_y * quat_i.quat_y;
      p_zz_q <= quat_i.quat_z * quat_i.quat_z;
      p_xy_q <= quat_i.quat_x * quat_i.quat_y;
      p_wz_q <= quat_i.quat_w * quat_i.quat_z;
    end
  end

  // Stage 1: sums rounded to Q14; then carried down the pipe
  q2a_pkg::side_t side_q [1:OUT_IDX-1];
  logic signed [SW-1:0] s_gx, s_gy, s_gz, s_yn, s_yd;

  assign s_gx = (SW'(p_xz_q) - SW'(p_wy_q)) <<< 1;
  assign s_gy = (SW'(p_wx_q) + SW'(p_yz_q)) <<< 1;
  assign s_gz = SW'(p_ww_q) - SW'(p_xx_q) - SW'(p_yy_q) + SW'(p_zz_q);
  assign s_yn = (SW'(p_xy_q) - SW'(p_wz_q)) <<< 1;
  assign s_yd = ((SW'(p_ww_q) + SW'(p_xx_q)) <<< 1) - 36'sd268435456;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1].gx <= q2a_pkg::rnd_q14(s_gx);
      side_q[1].gy <= q2a_pkg::rnd_q14(s_gy);
      side_q[1].gz <= q2a_pkg::rnd_q14(s_gz);
      side_q[1].yn <= q2a_pkg::rnd_q14(s_yn);
      side_q[1].yd <= q2a_pkg::rnd_q14(s_yd);
    end
  end

  for (genvar k = 2; k < OUT_IDX; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 2: squares; stage 3: radicand (gy^2 + gz^2) * 2^16
  logic signed [2*GW-1:0]      sq_gy_q, sq_gz_q;
  logic [q2a_pkg::RAD_W-1:0]   rad_q;
  logic [2*GW-1:0]             sq_sum;

  assign sq_sum = (2*GW)'(sq_gy_q) + (2*GW)'(sq_gz_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq_gy_q <= side_q[1].gy * side_q[1].gy;
      sq_gz_q <= side_q[1].gz * side_q[1].gz;
    end
    if (en[3]) begin
      rad_q <= {sq_sum, 16'b0};
    end
  end

  // Magnitude root
  logic [q2a_pkg::SQ_BITS-1:0] mag;

  q2a_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en[CD_FIRST-1:SQ_FIRST]),
    .rad_i  (rad_q),
    .root_o (mag)
  );

  // Three angle CORDICs fed from the same stage
  q2a_pkg::side_t       sd;
  logic signed [CIW-1:0] pitch_y;
  logic signed [q2a_pkg::ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;

  assign sd      = side_q[CD_FIRST-1];
  assign pitch_y = CIW'(sd.gx) <<< 8;

  q2a_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk_i (clk_i),
    .en_i  (en[OUT_IDX-1:CD_FIRST]),
    .y_i   (CIW'(sd.gy)),
    .x_i   (CIW'(sd.gz)),
    .ang_o (roll_ang)
  );

  q2a_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i (clk_i),
    .en_i  (en[OUT_IDX-1:CD_FIRST]),
    .y_i   (pitch_y),
    .x_i   (CIW'(mag)),
    .ang_o (pitch_ang)
  );

  q2a_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i (clk_i),
    .en_i  (en[OUT_IDX-1:CD_FIRST]),
    .y_i   (CIW'(sd.yn)),
    .x_i   (CIW'(sd.yd)),
    .ang_o (yaw_ang)
  );

  // Output register: gravity saturation and pitch fold for negative gz
  q2a_pkg::side_t sl;
  logic signed [q2a_pkg::ANG_W-1:0] pitch_f;
  logic signed [q2a_pkg::QW-1:0]    gx_q, gy_q, gz_q;
  logic signed [q2a_pkg::ANG_W-1:0] roll_q, pitch_q, yaw_q;

  assign sl = side_q[OUT_IDX-1];

  always_comb begin
    pitch_f = pitch_ang;
    if (sl.gz < 0) begin
      if (pitch_ang > 0) begin
        pitch_f = q2a_pkg::PI_Q13 - pitch_ang;
      end else begin
        pitch_f = -q2a_pkg::PI_Q13 - pitch_ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_IDX]) begin
      gx_q    <= q2a_pkg::sat_q14(sl.gx);
      gy_q    <= q2a_pkg::sat_q14(sl.gy);
      gz_q    <= q2a_pkg::sat_q14(sl.gz);
      roll_q  <= roll_ang;
      pitch_q <= pitch_f;
      yaw_q   <= yaw_ang;
    end
  end

  assign att_o.valid       = v_q[N-1];
  assign att_o.grav_x      = gx_q;
  assign att_o.grav_y      = gy_q;
  assign att_o.grav_z      = gz_q;
  assign att_o.roll_angle  = roll_q;
  assign att_o.pitch_angle = pitch_q;
  assign att_o.yaw_angle   = yaw_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int STAGES    = 16;
  localparam int LATENCY   = STAGES + 34;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1125;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } attitude_t;

  logic clk_i;
  logic rst_ni;

  q2a_quat_if quat_bus ();
  q2a_att_if  att_bus ();

  quaternion_to_attitude_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_bus.sink),
    .att_o  (att_bus.source)
  );

  quat_t     pending_quats[$];
  attitude_t expected_att[$];
  int        errors;
  int        accepted;
  int        received;
  int        idle_cycles;
  bit        stim_done;
  bit        hold_off;
  int        send_gap;
  int        recv_gap;
  bit        in_fire;
  bit        out_fire;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Floor shift for signed 64-bit values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q28_to_q14(longint v);
    return floor_shr(v + 8192, 14);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767, 16383, 8191,
                        4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  // Vectoring CORDIC atan2, Q13 radians
  function automatic longint cordic_atan2(longint yv, longint xv);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    if (xv == 0 && yv == 0) begin
      return 0;
    end
    if (xv < 0) begin
      ang = (yv >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      xv = -xv;
      yv = -yv;
    end
    xv = xv * 65536;
    yv = yv * 65536;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = floor_shr(xv, i);
      ys = floor_shr(yv, i);
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        ang += arctan_step(i);
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        ang -= arctan_step(i);
      end
    end
    ang = floor_shr(ang + 65536, 17);
    if (ang > 25736) ang = 25736;
    if (ang < -25736) ang = -25736;
    return ang;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic attitude_t predict_attitude(quat_t q);
    longint w, x, y, z, gx, gy, gz, yn, yd, mag, pitch;
    longint unsigned sum;
    attitude_t a;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    gx = q28_to_q14(2 * (x * z - w * y));
    gy = q28_to_q14(2 * (w * x + y * z));
    gz = q28_to_q14(w * w - x * x - y * y + z * z);
    yn = q28_to_q14(2 * (x * y - w * z));
    yd = q28_to_q14(2 * (w * w + x * x) - (64'sd1 << 28));
    sum = gy * gy + gz * gz;
    mag = int_sqrt(sum << 16);
    pitch = cordic_atan2(gx * 256, mag);
    if (gz < 0) begin
      pitch = (pitch > 0) ? 25736 - pitch : -25736 - pitch;
    end
    a.gx = clamp16(gx);
    a.gy = clamp16(gy);
    a.gz = clamp16(gz);
    a.roll = 16'(cordic_atan2(gy, gz));
    a.pitch = 16'(pitch);
    a.yaw = 16'(cordic_atan2(yn, yd));
    return a;
  endfunction

  // Random unit-ish quaternion: random direction scaled near 16384
  function automatic quat_t rand_unit_quat();
    quat_t q;
    longint c[4];
    longint n2;
    longint n;
    do begin
      for (int i = 0; i < 4; i++) c[i] = longint'($urandom_range(32766)) - 16383;
      n2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3];
    end while (n2 < 1000000);
    n = int_sqrt(n2);
    q.w = 16'(c[0] * 16384 / n);
    q.x = 16'(c[1] * 16384 / n);
    q.y = 16'(c[2] * 16384 / n);
    q.z = 16'(c[3] * 16384 / n);
    return q;
  endfunction

  function automatic quat_t mk(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w);
    q.x = 16'(x);
    q.y = 16'(y);
    q.z = 16'(z);
    return q;
  endfunction

  // Stimulus
  initial begin
    int k;
    errors = 0;
    stim_done = 0;
    hold_off = 0;
    quat_bus.valid = 1'b0;
    quat_bus.quat_w = '0;
    quat_bus.quat_x = '0;
    quat_bus.quat_y = '0;
    quat_bus.quat_z = '0;
    att_bus.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, axes, zero vector, extremes, folds
    pending_quats.push_back(mk(16384, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(0, 16384, 0, 0));
    pending_quats.push_back(mk(0, 0, 16384, 0));
    pending_quats.push_back(mk(0, 0, 0, 16384));
    pending_quats.push_back(mk(-16384, 0, 0, 0));
    pending_quats.push_back(mk(32767, 32767, 32767, 32767));
    pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
    pending_quats.push_back(mk(32767, -32768, 0, 0));
    pending_quats.push_back(mk(11585, 11585, 0, 0));
    pending_quats.push_back(mk(11585, -11585, 0, 0));
    pending_quats.push_back(mk(11585, 0, 11585, 0));
    pending_quats.push_back(mk(11585, 0, -11585, 0));
    pending_quats.push_back(mk(11585, 0, 0, 11585));
    pending_quats.push_back(mk(0, 11585, 11585, 0));
    pending_quats.push_back(mk(1, 0, 0, 0));
    pending_quats.push_back(mk(0, 1, 0, 0));
    pending_quats.push_back(mk(0, 0, 1, 1));
    pending_quats.push_back(mk(8192, 8192, 8192, 8192));
    pending_quats.push_back(mk(8192, -8192, 8192, -8192));
    pending_quats.push_back(mk(-1, -1, -1, -1));
    wait (pending_quats.size() == 0);

    // Drain completely before the random part
    hold_off = 1;
    wait (!quat_bus.valid);
    wait (expected_att.size() == 0);
    hold_off = 0;

    for (k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(9) < 7) begin
        pending_quats.push_back(rand_unit_quat());
      end else begin
        pending_quats.push_back(mk($urandom, $urandom, $urandom, $urandom));
      end
    end
    wait (pending_quats.size() == 0 && !quat_bus.valid);
    stim_done = 1;
  end

  // Driver
  always @(negedge clk_i) begin
    int gap;
    if (rst_ni) begin
      if (quat_bus.valid && !in_fire) begin
        // hold the request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        quat_bus.valid <= 1'b0;
      end else if (pending_quats.size() > 0 && !hold_off) begin
        quat_t q;
        q = pending_quats.pop_front();
        quat_bus.valid <= 1'b1;
        quat_bus.quat_w <= q.w;
        quat_bus.quat_x <= q.x;
        quat_bus.quat_y <= q.y;
        quat_bus.quat_z <= q.z;
        send_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(13);
      end else begin
        quat_bus.valid <= 1'b0;
      end
      // Receiver stall
      if (out_fire) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(13);
        recv_gap <= (gap > 0) ? gap - 1 : 0;
        att_bus.ready <= (gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        att_bus.ready <= 1'b0;
      end else begin
        att_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    accepted = 0;
    send_gap = 0;
    recv_gap = 0;
  end

  // Monitor: predict on accept, check on result
  always @(posedge clk_i) begin
    attitude_t e;
    attitude_t got;
    if (rst_ni) begin
      in_fire  <= quat_bus.valid && quat_bus.ready;
      out_fire <= att_bus.valid && att_bus.ready;
      if (quat_bus.valid && quat_bus.ready) begin
        accepted <= accepted + 1;
        expected_att.push_back(predict_attitude(mk(quat_bus.quat_w, quat_bus.quat_x,
                                                   quat_bus.quat_y, quat_bus.quat_z)));
      end
      if (att_bus.valid && att_bus.ready) begin
        received <= received + 1;
        got = {att_bus.grav_x, att_bus.grav_y, att_bus.grav_z, att_bus.roll_angle,
               att_bus.pitch_angle, att_bus.yaw_angle};
        if (expected_att.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          e = expected_att.pop_front();
          if (got.gx !== e.gx) begin
            $error("grav_x exp %0d got %0d", e.gx, got.gx); errors++;
          end
          if (got.gy !== e.gy) begin
            $error("grav_y exp %0d got %0d", e.gy, got.gy); errors++;
          end
          if (got.gz !== e.gz) begin
            $error("grav_z exp %0d got %0d", e.gz, got.gz); errors++;
          end
          if (got.roll !== e.roll) begin
            $error("roll_angle exp %0d got %0d", e.roll, got.roll); errors++;
          end
          if (got.pitch !== e.pitch) begin
            $error("pitch_angle exp %0d got %0d", e.pitch, got.pitch); errors++;
          end
          if (got.yaw !== e.yaw) begin
            $error("yaw_angle exp %0d got %0d", e.yaw, got.yaw); errors++;
          end
        end
      end
      if ((quat_bus.valid && quat_bus.ready) || (att_bus.valid && att_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    received = 0;
    idle_cycles = 0;
  end

  // End of run and watchdog
  initial begin
    wait (stim_done && expected_att.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Checked %0d quaternions, %0d attitude results, with random stalls.",
             accepted, received);
    if (errors == 0 && expected_att.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WDOG_MAX);
    $display("Watchdog: no requests moving");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
